@@ hw/rtl/a32cf_pkg.sv @@
// shared types and constants for the adler-32 checked frame deframer
// no dependencies; imported by every module of the block
`default_nettype none

package a32cf_pkg;

  // frame body length field width and hard upper bound on the body length
  localparam int unsigned LEN_W           = 27;
  localparam int unsigned MAX_FRAME_BYTES = 67108864;

  // header and checksum fields are both four bytes; a body needs room for both
  localparam int unsigned HDR_BYTES    = 4;
  localparam int unsigned MIN_BODY_LEN = 2 * HDR_BYTES;
  localparam int unsigned MIN_NAME_LEN = 2;

  // adler-32 modulus
  localparam logic [15:0] ADLER_MOD = 16'd65521;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_BODY,
    PH_HALT
  } phase_t;

  typedef enum logic [1:0] {
    RG_NAME_LEN  = 2'd0,
    RG_TYPE_NAME = 2'd1,
    RG_PAYLOAD   = 2'd2,
    RG_CHECKSUM  = 2'd3
  } region_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_BAD_FRAME_LEN = 2'd1,
    ST_BAD_SUM       = 2'd2,
    ST_BAD_NAME_LEN  = 2'd3
  } status_t;

  typedef enum logic {
    REG_MIN_LENGTH = 1'b0,
    REG_MAX_LENGTH = 1'b1
  } cfg_reg_t;

  // one result transfer
  typedef struct packed {
    logic [7:0] data;
    region_t    region;
    status_t    status;
    logic       last;
  } result_t;

  // control from the frame sequencer to the checksum unit
  typedef struct packed {
    logic clear;
    logic update;
  } adler_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/a32cf_adler.sv @@
// running adler-32 accumulator, one byte per cycle while update is set
// depends on a32cf_pkg
`default_nettype none

module a32cf_adler (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire a32cf_pkg::adler_ctl_t ctl,
  input  wire logic [7:0]            data_byte,
  output logic [31:0]                sum
);
  import a32cf_pkg::*;

  logic [15:0] low_r, low_nxt;
  logic [15:0] high_r, high_nxt;
  logic [16:0] low_add;
  logic [16:0] high_add;
  logic [16:0] low_red;
  logic [16:0] high_red;

  // low sum plus byte, one conditional subtract, then high sum likewise
  always_comb begin
    low_add  = {1'b0, low_r} + {9'd0, data_byte};
    low_red  = (low_add >= {1'b0, ADLER_MOD}) ? low_add - {1'b0, ADLER_MOD} : low_add;
    high_add = {1'b0, high_r} + low_red;
    high_red = (high_add >= {1'b0, ADLER_MOD}) ? high_add - {1'b0, ADLER_MOD} : high_add;
    low_nxt  = low_r;
    high_nxt = high_r;
    if (ctl.clear) begin
      low_nxt  = 16'd1;
      high_nxt = 16'd0;
    end else if (ctl.update) begin
      low_nxt  = low_red[15:0];
      high_nxt = high_red[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= 16'd1;
      high_r <= 16'd0;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

  assign sum = {high_r, low_r};

endmodule

`default_nettype wire

@@ hw/rtl/adler32_checked_frame_deframer.sv @@
// length-prefixed frame deframer with adler-32 body check
// depends on a32cf_pkg and a32cf_adler
// a result is registered in the output register, or in the skid while the output is held
// throughput: one input byte per cycle while in_stall is low; header bytes give no result but a length error
// a two-entry output stage (register plus skid) lets input flow while a result waits
// reset (rst_n low, synchronous) restores the limits and waits for a frame header;
// a bad frame length or checksum mismatch stops all results until the next reset
`default_nettype none

module adler32_checked_frame_deframer (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input byte stream
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [7:0]                  in_data_byte,
  // configuration writes
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [a32cf_pkg::LEN_W-1:0] cfg_wdata,
  // result stream
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [7:0]                       out_byte,
  output logic [1:0]                       out_region,
  output logic [1:0]                       out_status,
  output logic                             out_last
);
  import a32cf_pkg::*;

  // configuration
  logic [LEN_W-1:0] min_len_r;
  logic [LEN_W-1:0] max_len_r;

  // frame state
  phase_t           phase_r, phase_nxt;
  logic [1:0]       hdr_cnt_r, hdr_cnt_nxt;
  logic [31:0]      hdr_shift_r, hdr_shift_nxt;
  logic [LEN_W-1:0] len_m1_r, len_m1_nxt;
  logic [LEN_W-1:0] len_m4_r, len_m4_nxt;
  logic [LEN_W-1:0] len_m8_r, len_m8_nxt;
  logic [LEN_W-1:0] body_idx_r, body_idx_nxt;
  logic [31:0]      name_len_r, name_len_nxt;
  logic [31:0]      exp_sum_r, exp_sum_nxt;

  // output register and skid
  result_t          out_r, out_nxt;
  result_t          skid_r, skid_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic             skid_vld_r, skid_vld_nxt;

  logic             accept;
  logic             take;
  logic             hdr_done;
  logic [31:0]      hdr_len;
  logic             len_bad;
  logic             in_csum;
  logic             body_last;
  logic [31:0]      exp_shifted;
  logic             sum_bad;
  logic             name_ok;
  logic [LEN_W-1:0] name_off;
  logic             has_result;
  result_t          res;
  region_t          body_region;
  adler_ctl_t       adler_ctl;
  logic [31:0]      adler_sum;

  assign accept   = in_valid & ~in_stall;
  assign take     = out_vld_r & ~out_stall;
  assign in_stall = skid_vld_r;

  // checksum unit
  a32cf_adler u_adler (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (adler_ctl),
    .data_byte (in_data_byte),
    .sum       (adler_sum)
  );

  // decisions on the current byte
  always_comb begin
    hdr_done    = (hdr_cnt_r == 2'd3);
    hdr_len     = {hdr_shift_r[23:0], in_data_byte};
    len_bad     = hdr_len[31]
                | (hdr_len < {5'd0, min_len_r})
                | (hdr_len > {5'd0, max_len_r})
                | (hdr_len > 32'(MAX_FRAME_BYTES))
                | (hdr_len < 32'(MIN_BODY_LEN));
    in_csum     = (body_idx_r >= len_m4_r);
    body_last   = (body_idx_r == len_m1_r);
    exp_shifted = {exp_sum_r[23:0], in_data_byte};
    sum_bad     = (adler_sum != exp_shifted);
    name_ok     = ~name_len_r[31]
                & (name_len_r >= 32'(MIN_NAME_LEN))
                & (name_len_r <= {5'd0, len_m8_r});
    name_off    = body_idx_r - LEN_W'(HDR_BYTES);
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (hdr_done) phase_nxt = len_bad ? PH_HALT : PH_BODY;
        end
        PH_BODY: begin
          if (body_last) phase_nxt = sum_bad ? PH_HALT : PH_HEADER;
        end
        PH_HALT:   phase_nxt = PH_HALT;
        default:   phase_nxt = PH_HALT;
      endcase
    end
  end

  // region of a body byte
  always_comb begin
    priority if (body_idx_r < LEN_W'(HDR_BYTES)) begin
      body_region = RG_NAME_LEN;
    end else if (in_csum) begin
      body_region = RG_CHECKSUM;
    end else if (!name_len_r[31] && ({5'd0, name_off} < name_len_r)) begin
      body_region = RG_TYPE_NAME;
    end else begin
      body_region = RG_PAYLOAD;
    end
  end

  // datapath updates and result
  always_comb begin
    hdr_cnt_nxt   = hdr_cnt_r;
    hdr_shift_nxt = hdr_shift_r;
    len_m1_nxt    = len_m1_r;
    len_m4_nxt    = len_m4_r;
    len_m8_nxt    = len_m8_r;
    body_idx_nxt  = body_idx_r;
    name_len_nxt  = name_len_r;
    exp_sum_nxt   = exp_sum_r;
    adler_ctl     = '0;
    has_result    = 1'b0;
    res.data      = in_data_byte;
    res.region    = body_region;
    res.status    = ST_OK;
    res.last      = 1'b0;
    if (accept) begin
      unique case (phase_r)
        PH_HEADER: begin
          hdr_shift_nxt = hdr_len;
          hdr_cnt_nxt   = hdr_cnt_r + 2'd1;
          if (hdr_done) begin
            adler_ctl.clear = 1'b1;
            len_m1_nxt      = hdr_len[LEN_W-1:0] - LEN_W'(1);
            len_m4_nxt      = hdr_len[LEN_W-1:0] - LEN_W'(HDR_BYTES);
            len_m8_nxt      = hdr_len[LEN_W-1:0] - LEN_W'(MIN_BODY_LEN);
            body_idx_nxt    = '0;
            name_len_nxt    = '0;
            exp_sum_nxt     = '0;
            if (len_bad) begin
              has_result = 1'b1;
              res.data   = 8'd0;
              res.region = RG_NAME_LEN;
              res.status = ST_BAD_FRAME_LEN;
              res.last   = 1'b1;
            end
          end
        end
        PH_BODY: begin
          has_result   = 1'b1;
          body_idx_nxt = body_idx_r + LEN_W'(1);
          if (in_csum) exp_sum_nxt = exp_shifted;
          else         adler_ctl.update = 1'b1;
          if (body_idx_r < LEN_W'(HDR_BYTES)) name_len_nxt = {name_len_r[23:0], in_data_byte};
          if (body_last) begin
            res.last = 1'b1;
            if (sum_bad) begin
              res.status = ST_BAD_SUM;
            end else begin
              res.status    = name_ok ? ST_OK : ST_BAD_NAME_LEN;
              hdr_cnt_nxt   = 2'd0;
              hdr_shift_nxt = '0;
            end
          end
        end
        PH_HALT: begin
          has_result = 1'b0;
        end
        default: begin
          has_result = 1'b0;
        end
      endcase
    end
  end

  // output register with skid: skid fills only when the output is held
  always_comb begin
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    if (skid_vld_r) begin
      if (take) begin
        out_nxt      = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (has_result) begin
      if (!out_vld_r || take) begin
        out_nxt     = res;
        out_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = res;
        skid_vld_nxt = 1'b1;
      end
    end else if (take) begin
      out_vld_nxt = 1'b0;
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_len_r   <= LEN_W'(10);
      max_len_r   <= LEN_W'(MAX_FRAME_BYTES);
      phase_r     <= PH_HEADER;
      hdr_cnt_r   <= 2'd0;
      hdr_shift_r <= '0;
      len_m1_r    <= '0;
      len_m4_r    <= '0;
      len_m8_r    <= '0;
      body_idx_r  <= '0;
      name_len_r  <= '0;
      exp_sum_r   <= '0;
      out_vld_r   <= 1'b0;
      skid_vld_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_MIN_LENGTH: min_len_r <= cfg_wdata;
          REG_MAX_LENGTH: max_len_r <= cfg_wdata;
          default:        min_len_r <= min_len_r;
        endcase
      end
      phase_r     <= phase_nxt;
      hdr_cnt_r   <= hdr_cnt_nxt;
      hdr_shift_r <= hdr_shift_nxt;
      len_m1_r    <= len_m1_nxt;
      len_m4_r    <= len_m4_nxt;
      len_m8_r    <= len_m8_nxt;
      body_idx_r  <= body_idx_nxt;
      name_len_r  <= name_len_nxt;
      exp_sum_r   <= exp_sum_nxt;
      out_vld_r   <= out_vld_nxt;
      skid_vld_r  <= skid_vld_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid  = out_vld_r;
  assign out_byte   = out_r.data;
  assign out_region = out_r.region;
  assign out_status = out_r.status;
  assign out_last   = out_r.last;

endmodule

`default_nettype wire

@@ hw/rtl/a32cf_checker.sv @@
// port-level checks for the adler-32 checked frame deframer, bound to the top level
// depends on a32cf_pkg and adler32_checked_frame_deframer
`default_nettype none

module a32cf_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_byte,
  input wire logic [1:0] out_region,
  input wire logic [1:0] out_status,
  input wire logic       out_last
);
  import a32cf_pkg::*;

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("result changed while stalled");

  // a verdict only comes with the final transfer of a frame
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_status == ST_OK)
    else $error("non-ok status on a non-final transfer");

  // a length error carries a zero byte and the name-length region
  a_len_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_BAD_FRAME_LEN |->
      out_last && out_byte == 8'd0 && out_region == RG_NAME_LEN)
    else $error("malformed frame length error");

  // the final byte of a frame body is always a checksum byte
  a_last_region: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && out_status != ST_BAD_FRAME_LEN |->
      out_region == RG_CHECKSUM)
    else $error("final body byte outside the checksum region");

endmodule

bind adler32_checked_frame_deframer a32cf_checker u_a32cf_checker (.*);

`default_nettype wire

@@ verif/tb_top.sv @@
// self-checking testbench for the adler-32 checked frame deframer
// depends on a32cf_pkg and adler32_checked_frame_deframer; predicts every transfer itself
`timescale 1ns / 1ps

module tb_top;
  import a32cf_pkg::*;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned RANDOM_BYTES = 260;

  typedef enum logic [1:0] {
    FILL_ZERO,
    FILL_ONES,
    FILL_RANDOM
  } fill_t;

  // one directed frame: body length, name length field, body fill, optional fixed verdict
  typedef struct packed {
    logic [26:0] blen;
    logic [31:0] nlen;
    fill_t       fill;
    logic        typed;
    status_t     verdict;
  } frame_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        cfg_we;
  cfg_reg_t    cfg_index;
  logic [26:0] cfg_wdata;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic [1:0]  out_region;
  logic [1:0]  out_status;
  logic        out_last;

  adler32_checked_frame_deframer u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_region   (out_region),
    .out_status   (out_status),
    .out_last     (out_last)
  );

  // deframer state as it stands after reset
  phase_t      df_phase     = PH_HEADER;
  logic [1:0]  df_hdr_cnt   = '0;
  logic [31:0] df_hdr_shift = '0;
  logic [26:0] df_len       = '0;
  logic [26:0] df_idx       = '0;
  logic [31:0] df_nlen      = '0;
  logic [15:0] df_lo        = 16'd1;
  logic [15:0] df_hi        = '0;
  logic [31:0] df_sum_rx    = '0;
  logic [26:0] lim_min      = 27'd10;
  logic [26:0] lim_max      = 27'(MAX_FRAME_BYTES);

  result_t     forwarded_q[$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned bytes_sent   = 0;
  int unsigned frames_sent  = 0;
  int unsigned settings_used = 0;
  int unsigned idle_cycles  = 0;
  int unsigned cycle_cnt    = 0;
  bit          tx_steady    = 1'b0;
  string       halt_name;

  // directed frames at the reset limits
  frame_row_t frame_table [10] = '{
    '{27'd10,  32'd2,          FILL_ZERO,   1'b1, ST_OK},
    '{27'd10,  32'd1,          FILL_RANDOM, 1'b1, ST_BAD_NAME_LEN},
    '{27'd10,  32'd3,          FILL_ONES,   1'b1, ST_BAD_NAME_LEN},
    '{27'd10,  32'd0,          FILL_ZERO,   1'b1, ST_BAD_NAME_LEN},
    '{27'd12,  32'h8000_0000,  FILL_RANDOM, 1'b1, ST_BAD_NAME_LEN},
    '{27'd12,  32'hFFFF_FFFF,  FILL_ONES,   1'b1, ST_BAD_NAME_LEN},
    '{27'd14,  32'd6,          FILL_ONES,   1'b1, ST_OK},
    '{27'd16,  32'h7FFF_FFFF,  FILL_RANDOM, 1'b1, ST_BAD_NAME_LEN},
    '{27'd300, 32'd2,          FILL_ONES,   1'b1, ST_OK},
    '{27'd40,  32'd5,          FILL_RANDOM, 1'b0, ST_OK}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // next deframer result for one accepted byte; returns 1 when a result is due
  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [31:0] len;
    logic [26:0] idx;
    logic [16:0] lo_sum;
    logic [16:0] hi_sum;
    region_t     rg;
    bit          made;
    made = 1'b0;
    r = '{data: 8'h00, region: RG_NAME_LEN, status: ST_OK, last: 1'b0};
    case (df_phase)
      PH_HEADER: begin
        df_hdr_shift = {df_hdr_shift[23:0], b};
        df_hdr_cnt   = df_hdr_cnt + 2'd1;
        if (df_hdr_cnt == 2'd0) begin
          len = df_hdr_shift;
          if (len[31] || len < lim_min || len > lim_max || len > MAX_FRAME_BYTES ||
              len < MIN_BODY_LEN) begin
            // bad frame length: error transfer, then stop for good
            df_phase = PH_HALT;
            r.status = ST_BAD_FRAME_LEN;
            r.last   = 1'b1;
            made     = 1'b1;
          end else begin
            df_len    = len[26:0];
            df_idx    = '0;
            df_nlen   = '0;
            df_lo     = 16'd1;
            df_hi     = '0;
            df_sum_rx = '0;
            df_phase  = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        idx = df_idx;
        // running checksum over everything before the stored sum
        if (idx < df_len - 27'd4) begin
          lo_sum = {1'b0, df_lo} + b;
          if (lo_sum >= ADLER_MOD) lo_sum = lo_sum - ADLER_MOD;
          df_lo  = lo_sum[15:0];
          hi_sum = {1'b0, df_hi} + df_lo;
          if (hi_sum >= ADLER_MOD) hi_sum = hi_sum - ADLER_MOD;
          df_hi  = hi_sum[15:0];
        end else begin
          df_sum_rx = {df_sum_rx[23:0], b};
        end
        // region tag
        if (idx < 27'd4) begin
          rg      = RG_NAME_LEN;
          df_nlen = {df_nlen[23:0], b};
        end else if (idx >= df_len - 27'd4) begin
          rg = RG_CHECKSUM;
        end else if (!df_nlen[31] && ({5'd0, idx - 27'd4} < df_nlen)) begin
          rg = RG_TYPE_NAME;
        end else begin
          rg = RG_PAYLOAD;
        end
        df_idx   = idx + 27'd1;
        r.data   = b;
        r.region = rg;
        made     = 1'b1;
        // verdict on the final body byte, checksum first
        if (idx + 27'd1 == df_len) begin
          r.last = 1'b1;
          if ({df_hi, df_lo} != df_sum_rx) begin
            r.status = ST_BAD_SUM;
            df_phase = PH_HALT;
          end else begin
            if (!df_nlen[31] && df_nlen >= MIN_NAME_LEN && df_nlen <= {5'd0, df_len - 27'd8})
              r.status = ST_OK;
            else
              r.status = ST_BAD_NAME_LEN;
            df_phase     = PH_HEADER;
            df_hdr_cnt   = '0;
            df_hdr_shift = '0;
          end
        end
      end
      default: ;
    endcase
    return made;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned gap_len(input bit steady);
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [26:0] pick_len();
    logic [26:0] top;
    top = (lim_max - lim_min > 27'd40) ? lim_min + 27'd40 : lim_max;
    if ($urandom_range(19) == 0 && lim_max - lim_min >= 27'd100)
      top = (lim_max - lim_min > 27'd400) ? lim_min + 27'd400 : lim_max;
    return lim_min + 27'($urandom_range(top - lim_min));
  endfunction

  // mostly a fitting name length, otherwise short, too long, negative or huge
  function automatic logic [31:0] pick_name_len(input logic [26:0] blen);
    case ($urandom_range(15))
      0:       return 32'($urandom_range(1));
      1:       return 32'(blen) - 32'd7 + $urandom_range(20);
      2:       return {1'b1, 31'($urandom)};
      3:       return $urandom_range(32'h7FFF_FFFF, 32'h0100_0000);
      default: return $urandom_range(32'(blen) - 32'd8, 32'd2);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input result_t want, input result_t got);
    if (mismatches < 10) begin
      $write("%0t %s: want byte %02h region %0d status %0d last %0d, ",
             $time, what, want.data, want.region, want.status, want.last);
      $display("got byte %02h region %0d status %0d last %0d",
               got.data, got.region, got.status, got.last);
    end
    mismatches++;
  endtask

  // offer one byte, wait for its transfer and predict its result
  task automatic send_byte(input logic [7:0] b, input bit typed, input status_t verdict);
    int unsigned gap;
    result_t     r;
    gap = gap_len(tx_steady);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (deframe_byte(b, r)) begin
      if (typed && r.last) r.status = verdict;
      forwarded_q.push_back(r);
    end
  endtask

  task automatic send_word(input logic [31:0] w, input bit typed, input status_t verdict);
    for (int k = 0; k < 4; k++) send_byte(w[31 - 8 * k -: 8], typed, verdict);
  endtask

  // header, name length field, fill and adler-32 trailer
  task automatic send_frame(input logic [26:0] blen, input logic [31:0] nlen, input fill_t fill,
                            input bit typed, input status_t verdict, input bit corrupt);
    logic [7:0]  body[$];
    int unsigned lo;
    int unsigned hi;
    int unsigned flip;
    logic [31:0] sum;
    body = {};
    for (int k = 0; k < 4; k++) body.push_back(nlen[31 - 8 * k -: 8]);
    while (body.size() < int'(blen) - 4) begin
      case (fill)
        FILL_ZERO: body.push_back(8'h00);
        FILL_ONES: body.push_back(8'hFF);
        default:   body.push_back(8'($urandom));
      endcase
    end
    lo = 1;
    hi = 0;
    foreach (body[j]) begin
      lo = (lo + body[j]) % ADLER_MOD;
      hi = (hi + lo) % ADLER_MOD;
    end
    sum = {hi[15:0], lo[15:0]};
    if (corrupt) begin
      flip      = $urandom_range(31);
      sum[flip] = ~sum[flip];
    end
    for (int k = 0; k < 4; k++) body.push_back(sum[31 - 8 * k -: 8]);
    send_word(32'(blen), 1'b0, ST_OK);
    foreach (body[j]) send_byte(body[j], typed, verdict);
    frames_sent++;
  endtask

  // sender pauses until every result is back, then lets the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (forwarded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_limits(input logic [26:0] lo, input logic [26:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MIN_LENGTH;
    cfg_wdata <= lo;
    @(posedge clk);
    lim_min = lo;
    cfg_index <= REG_MAX_LENGTH;
    cfg_wdata <= hi;
    @(posedge clk);
    lim_max = hi;
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // main stimulus
  initial begin : stimulus
    int unsigned phase_no;
    int unsigned phase_end;
    logic [26:0] lo;
    logic [26:0] blen;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_MIN_LENGTH;
    cfg_wdata    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames at the reset limits
    foreach (frame_table[i])
      send_frame(frame_table[i].blen, frame_table[i].nlen, frame_table[i].fill,
                 frame_table[i].typed, frame_table[i].verdict, 1'b0);

    // random phases, each under its own length limits
    phase_no = 0;
    phase_end = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < phase_end) begin
      drain();
      case ((phase_no < 2) ? phase_no : $urandom_range(3))
        0: set_limits(27'd10, 27'd10);
        1: set_limits(27'd10, 27'(MAX_FRAME_BYTES));
        2: begin
          lo = 27'($urandom_range(40, 10));
          set_limits(lo, lo + 27'($urandom_range(60)));
        end
        default: set_limits(27'($urandom_range(60, 10)), 27'(MAX_FRAME_BYTES));
      endcase
      tx_steady = ($urandom_range(3) == 0);
      phase_no++;
      lo = 27'(bytes_sent + $urandom_range(160, 60));
      while (bytes_sent < lo && bytes_sent < phase_end) begin
        blen = pick_len();
        send_frame(blen, pick_name_len(blen), FILL_RANDOM, 1'b0, ST_OK, 1'b0);
      end
    end
    drain();
    tx_steady = 1'b0;

    // end on one halting error, then show that later bytes are ignored
    case ($urandom_range(5))
      0: begin
        halt_name = "checksum mismatch";
        blen = pick_len();
        send_frame(blen, pick_name_len(blen), FILL_RANDOM, 1'b1, ST_BAD_SUM, 1'b1);
      end
      1: begin
        halt_name = "negative frame length";
        send_word({1'b1, 31'($urandom)}, 1'b1, ST_BAD_FRAME_LEN);
      end
      2: begin
        halt_name = "length below min_length";
        set_limits(27'($urandom_range(80, 20)), 27'(MAX_FRAME_BYTES));
        send_word($urandom_range(32'(lim_min) - 1, 0), 1'b1, ST_BAD_FRAME_LEN);
      end
      3: begin
        halt_name = "length above max_length";
        set_limits(27'd10, 27'($urandom_range(200, 10)));
        if ($urandom_range(1) == 0)
          send_word(32'(lim_max) + 32'd1, 1'b1, ST_BAD_FRAME_LEN);
        else
          send_word($urandom_range(32'h7FFF_FFFF, 32'(lim_max) + 1), 1'b1, ST_BAD_FRAME_LEN);
      end
      4: begin
        halt_name = "crossed limits";
        set_limits(27'($urandom_range(80, 41)), 27'($urandom_range(40, 10)));
        send_word($urandom_range(100, 10), 1'b1, ST_BAD_FRAME_LEN);
      end
      default: begin
        halt_name = "min_length at its ceiling";
        set_limits(27'(MAX_FRAME_BYTES), 27'(MAX_FRAME_BYTES));
        send_word($urandom_range(4096, 8), 1'b1, ST_BAD_FRAME_LEN);
      end
    endcase
    repeat (16) send_byte(8'($urandom), 1'b0, ST_OK);
    in_valid <= 1'b0;

    // wait out the last results and the output register
    while (forwarded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d frames, %0d stream bytes, %0d checked results, %0d limit settings",
             frames_sent, bytes_sent, results_seen, settings_used);
    $display("stream ended on %s with trailing bytes ignored", halt_name);
    if (mismatches == 0 && forwarded_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // receiver: random stalls, calm windows and two long hold-offs
  initial begin : result_sink
    int unsigned gap;
    int unsigned holds_done;
    holds_done = 0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (holds_done < 2 && results_seen >= ((holds_done == 0) ? 60 : 600)) begin
        gap = LONG_HOLD;
        holds_done++;
      end else if (cycle_cnt[9:8] == 2'b00) begin
        gap = 0;
      end else begin
        gap = gap_len(1'b0);
      end
      if (gap != 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{data: out_byte, region: region_t'(out_region), status: status_t'(out_status),
              last: out_last};
      results_seen++;
      if (forwarded_q.size() == 0) begin
        report_mismatch("result with nothing pending", '0, got);
      end else begin
        want = forwarded_q.pop_front();
        if (got.data !== want.data || got.region !== want.region ||
            got.status !== want.status || got.last !== want.last)
          report_mismatch("result mismatch", want, got);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               STALL_LIMIT, forwarded_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
